>>> hw/rtl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types, codes and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int ARENA_BYTES  = 4096;
    localparam int HEADER_BYTES = 12;
    localparam int ADDR_W       = 12;
    localparam int SIZE_W       = 12;
    localparam int OFF_W        = 13;
    localparam int FUNC_W       = 2;
    localparam int STATUS_W     = 2;

    localparam logic BLK_TAKEN = 1'b0;
    localparam logic BLK_FREE  = 1'b1;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 2'd3;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic              free;
        logic              linked;
        logic [ADDR_W-1:0] next;
    } hdr_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_START,
        CMD_READ,
        CMD_EVAL,
        CMD_SPLIT_H,
        CMD_MREAD,
        CMD_MCUR,
        CMD_MNEXT,
        CMD_EMIT
    } cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              bad;
        logic              hit;
        logic              split;
        logic              link_ok;
        logic              out_busy;
    } dp_status_t;

endpackage

>>> hw/rtl/ffba_in_if.sv
// ----------------------------------------------------------------------------
// ffba_in_if
// Request channel: operation code, request size and payload offset.
// ----------------------------------------------------------------------------
interface ffba_in_if;
    logic                           valid;
    logic                           ready;
    logic [ffba_pkg::FUNC_W-1:0]    func;
    logic [ffba_pkg::SIZE_W-1:0]    request_bytes;
    logic [ffba_pkg::OFF_W-1:0]     payload_offset;

    modport source (output valid, output func, output request_bytes,
                    output payload_offset, input ready);
    modport sink (input valid, input func, input request_bytes,
                  input payload_offset, output ready);
endinterface

>>> hw/rtl/ffba_out_if.sv
// ----------------------------------------------------------------------------
// ffba_out_if
// Response channel: status, granted offset and block size.
// ----------------------------------------------------------------------------
interface ffba_out_if;
    logic                           valid;
    logic                           ready;
    logic [ffba_pkg::STATUS_W-1:0]  status;
    logic [ffba_pkg::ADDR_W-1:0]    granted_offset;
    logic [ffba_pkg::SIZE_W-1:0]    block_bytes;

    modport source (output valid, output status, output granted_offset,
                    output block_bytes, input ready);
    modport sink (input valid, input status, input granted_offset,
                  input block_bytes, output ready);
endinterface

>>> hw/rtl/ffba_datapath.sv
// ----------------------------------------------------------------------------
// ffba_datapath
// Header memory, chain walk registers, merge arithmetic and response register.
// ----------------------------------------------------------------------------
module ffba_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ffba_pkg::cmd_t                cmd,
    output ffba_pkg::dp_status_t          st,
    input  logic [ffba_pkg::FUNC_W-1:0]   in_func,
    input  logic [ffba_pkg::SIZE_W-1:0]   in_request_bytes,
    input  logic [ffba_pkg::OFF_W-1:0]    in_payload_offset,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ffba_pkg::STATUS_W-1:0] out_status,
    output logic [ffba_pkg::ADDR_W-1:0]   out_granted_offset,
    output logic [ffba_pkg::SIZE_W-1:0]   out_block_bytes
);
    import ffba_pkg::*;

    localparam logic [OFF_W-1:0] HDR_OFF   = OFF_W'(HEADER_BYTES);
    localparam logic [OFF_W-1:0] ARENA_OFF = OFF_W'(ARENA_BYTES);

    hdr_t mem [ARENA_BYTES];
    hdr_t rd_data_reg;

    logic [FUNC_W-1:0]   func_reg;
    logic [SIZE_W-1:0]   req_reg;
    logic [OFF_W-1:0]    off_reg;
    logic [ADDR_W-1:0]   h_reg, h_next;
    hdr_t                cur_reg, cur_next;
    logic                arena_ready_reg, arena_ready_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ADDR_W-1:0]   res_granted_reg, res_granted_next;
    logic [SIZE_W-1:0]   res_bytes_reg, res_bytes_next;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [ADDR_W-1:0]   out_granted_reg;
    logic [SIZE_W-1:0]   out_bytes_reg;

    logic              we, re;
    logic [ADDR_W-1:0] waddr, raddr;
    hdr_t              wdata, merged;
    logic              bad_size, bad_addr, hit, split, link_ok;
    logic [OFF_W-1:0]  h_payload, rem_off, req_plus_hdr;

    function automatic logic chain_ok(hdr_t hd, logic [ADDR_W-1:0] at);
        chain_ok = hd.linked && (hd.next > at);
    endfunction

    always_comb
    begin
        h_payload    = {1'b0, h_reg} + HDR_OFF;
        req_plus_hdr = {1'b0, req_reg} + HDR_OFF;
        rem_off      = h_payload + {1'b0, req_reg};
        bad_size     = (func_reg == FUNC_ALLOC && req_reg == '0)
                       || (func_reg != FUNC_ALLOC && func_reg != FUNC_FREE
                           && func_reg != FUNC_QUERY);
        bad_addr     = (func_reg == FUNC_FREE || func_reg == FUNC_QUERY)
                       && (off_reg < HDR_OFF || off_reg > ARENA_OFF);
        if (func_reg == FUNC_ALLOC)
        begin
            hit = (rd_data_reg.free == BLK_FREE) && (rd_data_reg.size >= req_reg);
        end
        else
        begin
            hit = (h_payload == off_reg);
        end
        split  = {1'b0, rd_data_reg.size} > req_plus_hdr;
        merged.size   = SIZE_W'({1'b0, cur_reg.size} + {1'b0, rd_data_reg.size} + HDR_OFF);
        merged.free   = BLK_FREE;
        merged.linked = rd_data_reg.linked;
        merged.next   = rd_data_reg.next;

        we               = 1'b0;
        waddr            = h_reg;
        wdata            = rd_data_reg;
        re               = 1'b0;
        raddr            = h_reg;
        link_ok          = 1'b0;
        h_next           = h_reg;
        cur_next         = cur_reg;
        arena_ready_next = arena_ready_reg;
        res_status_next  = res_status_reg;
        res_granted_next = res_granted_reg;
        res_bytes_next   = res_bytes_reg;

        unique case (cmd)
            CMD_START:
            begin
                if (!arena_ready_reg)
                begin
                    we               = 1'b1;
                    waddr            = '0;
                    wdata.size       = SIZE_W'(ARENA_BYTES - HEADER_BYTES);
                    wdata.free       = BLK_FREE;
                    wdata.linked     = 1'b0;
                    wdata.next       = '0;
                    arena_ready_next = 1'b1;
                end
                h_next           = '0;
                res_granted_next = '0;
                res_bytes_next   = '0;
                priority if (bad_size)
                    res_status_next = ST_BAD_SIZE;
                else if (bad_addr)
                    res_status_next = ST_BAD_ADDR;
                else
                    res_status_next = ST_OK;
            end
            CMD_READ, CMD_MREAD:
            begin
                re = 1'b1;
            end
            CMD_EVAL:
            begin
                link_ok = chain_ok(rd_data_reg, h_reg);
                if (hit)
                begin
                    if (func_reg == FUNC_ALLOC)
                    begin
                        we = 1'b1;
                        res_granted_next = h_payload[ADDR_W-1:0];
                        if (split)
                        begin
                            waddr      = rem_off[ADDR_W-1:0];
                            wdata.size = SIZE_W'({1'b0, rd_data_reg.size} - req_plus_hdr);
                            wdata.free = BLK_FREE;
                            res_bytes_next = req_reg;
                        end
                        else
                        begin
                            wdata.free     = BLK_TAKEN;
                            res_bytes_next = rd_data_reg.size;
                        end
                    end
                    else if (func_reg == FUNC_QUERY)
                    begin
                        res_bytes_next = rd_data_reg.size;
                    end
                    else
                    begin
                        we         = 1'b1;
                        wdata.free = BLK_FREE;
                        h_next     = '0;
                    end
                end
                else if (link_ok)
                begin
                    h_next = rd_data_reg.next;
                end
                else
                begin
                    res_status_next = (func_reg == FUNC_ALLOC) ? ST_NO_SPACE : ST_BAD_ADDR;
                end
            end
            CMD_SPLIT_H:
            begin
                we           = 1'b1;
                wdata.size   = req_reg;
                wdata.free   = BLK_TAKEN;
                wdata.linked = 1'b1;
                wdata.next   = rem_off[ADDR_W-1:0];
            end
            CMD_MCUR:
            begin
                cur_next = rd_data_reg;
                link_ok  = chain_ok(rd_data_reg, h_reg);
                re       = link_ok;
                raddr    = rd_data_reg.next;
            end
            CMD_MNEXT:
            begin
                if (cur_reg.free == BLK_FREE && rd_data_reg.free == BLK_FREE)
                begin
                    we       = 1'b1;
                    wdata    = merged;
                    cur_next = merged;
                    link_ok  = chain_ok(merged, h_reg);
                    raddr    = merged.next;
                end
                else
                begin
                    h_next   = cur_reg.next;
                    cur_next = rd_data_reg;
                    link_ok  = chain_ok(rd_data_reg, cur_reg.next);
                    raddr    = rd_data_reg.next;
                end
                re = link_ok;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd == CMD_LOAD)
        begin
            func_reg <= in_func;
            req_reg  <= in_request_bytes;
            off_reg  <= in_payload_offset;
        end
        h_reg           <= h_next;
        cur_reg         <= cur_next;
        res_status_reg  <= res_status_next;
        res_granted_reg <= res_granted_next;
        res_bytes_reg   <= res_bytes_next;
        if (cmd == CMD_EMIT)
        begin
            out_status_reg  <= res_status_reg;
            out_granted_reg <= res_granted_reg;
            out_bytes_reg   <= res_bytes_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arena_ready_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            arena_ready_reg <= arena_ready_next;
            if (cmd == CMD_EMIT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign st.func     = func_reg;
    assign st.bad      = bad_size || bad_addr;
    assign st.hit      = hit;
    assign st.split    = split;
    assign st.link_ok  = link_ok;
    assign st.out_busy = out_valid_reg && !out_ready;

    assign out_valid          = out_valid_reg;
    assign out_status         = out_status_reg;
    assign out_granted_offset = out_granted_reg;
    assign out_block_bytes    = out_bytes_reg;

    a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
        we && re |-> waddr != raddr)
        else $error("header read and write hit the same entry");

    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == CMD_EMIT |-> !out_valid_reg || out_ready)
        else $error("response overwritten before transfer");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == CMD_EMIT && res_status_reg != ST_OK |=>
            out_granted_reg == '0 && out_bytes_reg == '0)
        else $error("failed response carries nonzero fields");

    a_ready_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == CMD_START |=> arena_ready_reg)
        else $error("arena not set up after first operation");

endmodule

>>> hw/rtl/ffba_ctrl.sv
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer for setup, chain walk, split, merge walk and response hand-off.
// ----------------------------------------------------------------------------
module ffba_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ffba_pkg::dp_status_t st,
    output ffba_pkg::cmd_t       cmd
);
    import ffba_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_READ,
        S_EVAL,
        S_SPLIT_H,
        S_MREAD,
        S_MCUR,
        S_MNEXT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd        = CMD_START;
                state_next = st.bad ? S_DONE : S_READ;
            end
            S_READ:
            begin
                cmd        = CMD_READ;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd = CMD_EVAL;
                priority if (st.hit && st.func == FUNC_ALLOC)
                    state_next = st.split ? S_SPLIT_H : S_DONE;
                else if (st.hit && st.func == FUNC_FREE)
                    state_next = S_MREAD;
                else if (st.hit)
                    state_next = S_DONE;
                else if (st.link_ok)
                    state_next = S_READ;
                else
                    state_next = S_DONE;
            end
            S_SPLIT_H:
            begin
                cmd        = CMD_SPLIT_H;
                state_next = S_DONE;
            end
            S_MREAD:
            begin
                cmd        = CMD_MREAD;
                state_next = S_MCUR;
            end
            S_MCUR:
            begin
                cmd        = CMD_MCUR;
                state_next = st.link_ok ? S_MNEXT : S_DONE;
            end
            S_MNEXT:
            begin
                cmd        = CMD_MNEXT;
                state_next = st.link_ok ? S_MNEXT : S_DONE;
            end
            S_DONE:
            begin
                if (!st.out_busy)
                begin
                    cmd        = CMD_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

>>> hw/rtl/first_fit_block_allocator_core.sv
// First-fit allocator over a 4096-byte arena of 12-byte headers plus payload.
// Each request is taken, worked on alone and answered with one response; the
// response register lets the next request in while a response waits. Cost is
// set by the header memory, with one write and one read port: each chain
// header read up to and including the match takes a read state and an
// evaluate state after the load and start states, and a split adds a split
// state; a request rejected on size or offset range goes from start to done.
// A free adds a merge walk from the chain head that joins adjacent free
// blocks. A response that still waits at the output holds the finished
// request until it transfers. The first request also sets up the arena in
// its start cycle. The header memory has no clearing pass and no reset.
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core
// Top level: joins the sequencer, the datapath and the two channels.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_core (
    input  logic clk,
    input  logic rst_n,
    ffba_in_if.sink    item,
    ffba_out_if.source result
);
    import ffba_pkg::*;

    cmd_t       cmd;
    dp_status_t st;

    ffba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .st       (st),
        .cmd      (cmd)
    );

    ffba_datapath u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .st                 (st),
        .in_func            (item.func),
        .in_request_bytes   (item.request_bytes),
        .in_payload_offset  (item.payload_offset),
        .out_valid          (result.valid),
        .out_ready          (result.ready),
        .out_status         (result.status),
        .out_granted_offset (result.granted_offset),
        .out_block_bytes    (result.block_bytes)
    );

endmodule
